// ===== rtl/cst_pkg.sv =====
`timescale 1ns / 1ps
package cst_pkg;

  localparam int unsigned MAX_TEXT_BYTES = 1048576;
  localparam int unsigned POS_W = $clog2(MAX_TEXT_BYTES + 1);

  localparam int unsigned CLASS_W  = 5;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned LENGTH_W = 21;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RCNT_W = $clog2(MAX_RESULTS + 1);

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [CLASS_W-1:0]  token_class;
    logic [OFFSET_W-1:0] token_offset;
    logic [LENGTH_W-1:0] token_length;
    logic                last_of_run;
  } result_t;

  typedef struct packed {
    logic [RCNT_W-1:0]             cnt;
    result_t [MAX_RESULTS-1:0]     item;
  } push_t;

endpackage

// ===== rtl/cst_lexer.sv =====
`timescale 1ns / 1ps
module cst_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         text_byte,
  input  logic               final_byte,
  output cst_pkg::push_t     push
);

  localparam int unsigned PW = cst_pkg::POS_W;
  localparam logic [PW-1:0] POS_MAX = PW'(cst_pkg::MAX_TEXT_BYTES);
  localparam logic [cst_pkg::OFFSET_W-1:0] OFF_SAT = '1;

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_SLASH      = 4'd1;
  localparam logic [3:0] M_LINE       = 4'd2;
  localparam logic [3:0] M_BLOCK      = 4'd3;
  localparam logic [3:0] M_BLOCK_STAR = 4'd4;
  localparam logic [3:0] M_NUMBER     = 4'd5;
  localparam logic [3:0] M_IDENT      = 4'd6;
  localparam logic [3:0] M_CHAR       = 4'd7;
  localparam logic [3:0] M_CHAR_ESC   = 4'd8;
  localparam logic [3:0] M_STRING     = 4'd9;
  localparam logic [3:0] M_STRING_ESC = 4'd10;

  localparam logic [4:0] C_SLASH   = 5'd14;
  localparam logic [4:0] C_IDENT   = 5'd21;
  localparam logic [4:0] C_NUMBER  = 5'd22;
  localparam logic [4:0] C_CHAR    = 5'd23;
  localparam logic [4:0] C_STRING  = 5'd24;
  localparam logic [4:0] C_UNKNOWN = 5'd25;
  localparam logic [4:0] C_END     = 5'd26;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;

  function automatic logic [5:0] punct_lookup(input logic [7:0] b);
    logic [5:0] r;
    r = '0;
    unique case (b)
      8'h28: r = {1'b1, 5'd0};
      8'h29: r = {1'b1, 5'd1};
      8'h7B: r = {1'b1, 5'd2};
      8'h7D: r = {1'b1, 5'd3};
      8'h5B: r = {1'b1, 5'd4};
      8'h5D: r = {1'b1, 5'd5};
      8'h2C: r = {1'b1, 5'd6};
      8'h2E: r = {1'b1, 5'd7};
      8'h2A: r = {1'b1, 5'd8};
      8'h2D: r = {1'b1, 5'd9};
      8'h2B: r = {1'b1, 5'd10};
      8'h21: r = {1'b1, 5'd11};
      8'h7E: r = {1'b1, 5'd12};
      8'h5C: r = {1'b1, 5'd13};
      8'h2F: r = {1'b1, 5'd14};
      8'h3D: r = {1'b1, 5'd15};
      8'h26: r = {1'b1, 5'd16};
      8'h23: r = {1'b1, 5'd17};
      8'h3B: r = {1'b1, 5'd18};
      8'h3A: r = {1'b1, 5'd19};
      8'h3F: r = {1'b1, 5'd20};
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [3:0]    mode_r, mode_nxt;
  logic [1:0]    esc_r, esc_nxt;
  logic [PW-1:0] begin_r, begin_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic [PW-1:0] pos_next;
  logic          restart;
  logic          is_space, is_dec, is_word;
  logic [5:0]    punct;
  logic [3:0]    c_v;
  logic [4:0]    c_cls [4];
  logic [PW-1:0] c_beg [4];
  logic [PW-1:0] c_end [4];
  logic [1:0]    n;
  cst_pkg::push_t push_c;

  assign pos_next = (pos_r < POS_MAX) ? pos_r + PW'(1) : POS_MAX;
  assign is_space = (text_byte == CH_SPACE) || (text_byte >= CH_TAB && text_byte <= CH_CR);
  assign is_dec   = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign is_word  = (text_byte >= 8'h61 && text_byte <= 8'h7A) ||
                    (text_byte >= 8'h41 && text_byte <= 8'h5A) || (text_byte == 8'h5F);
  assign punct    = punct_lookup(text_byte);

  always_comb begin
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    begin_nxt = begin_r;
    pos_nxt   = pos_r;
    restart   = 1'b0;
    c_v       = '0;
    for (int k = 0; k < 4; k++) begin
      c_cls[k] = C_END;
      c_beg[k] = pos_next;
      c_end[k] = pos_next;
    end

    unique case (mode_r)
      M_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_nxt = M_LINE;
        end else if (text_byte == CH_STAR) begin
          mode_nxt = M_BLOCK;
        end else begin
          c_v[0] = 1'b1; c_cls[0] = C_SLASH; c_beg[0] = begin_r; c_end[0] = pos_r;
          restart = 1'b1;
        end
      end
      M_LINE: begin
        if (text_byte == CH_NL) mode_nxt = M_IDLE;
      end
      M_BLOCK: begin
        if (text_byte == CH_STAR) mode_nxt = M_BLOCK_STAR;
      end
      M_BLOCK_STAR: begin
        if (text_byte == CH_SLASH) mode_nxt = M_IDLE;
        else if (text_byte != CH_STAR) mode_nxt = M_BLOCK;
      end
      M_NUMBER: begin
        if (!(is_dec || text_byte == CH_DOT || text_byte == CH_LX || text_byte == CH_UX)) begin
          c_v[0] = 1'b1; c_cls[0] = C_NUMBER; c_beg[0] = begin_r; c_end[0] = pos_r;
          restart = 1'b1;
        end
      end
      M_IDENT: begin
        if (!(is_word || is_dec)) begin
          c_v[0] = 1'b1; c_cls[0] = C_IDENT; c_beg[0] = begin_r; c_end[0] = pos_r;
          restart = 1'b1;
        end
      end
      M_CHAR, M_STRING: begin
        if (esc_r != 2'd0) begin
          esc_nxt = esc_r - 2'd1;
        end else if (text_byte == CH_BSLASH) begin
          mode_nxt = (mode_r == M_CHAR) ? M_CHAR_ESC : M_STRING_ESC;
        end else if ((mode_r == M_CHAR && text_byte == CH_SQUOTE) ||
                     (mode_r == M_STRING && text_byte == CH_DQUOTE)) begin
          c_v[1]   = 1'b1;
          c_cls[1] = (mode_r == M_CHAR) ? C_CHAR : C_STRING;
          c_beg[1] = begin_r;
          c_end[1] = pos_next;
          mode_nxt = M_IDLE;
        end
      end
      M_CHAR_ESC, M_STRING_ESC: begin
        esc_nxt  = (text_byte == CH_LX) ? 2'd2 : 2'd0;
        mode_nxt = (mode_r == M_CHAR_ESC) ? M_CHAR : M_STRING;
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      mode_nxt = M_IDLE;
      priority if (is_space) begin
        mode_nxt = M_IDLE;
      end else if (text_byte == CH_HASH && !final_byte) begin
        mode_nxt = M_LINE;
      end else if (text_byte == CH_SLASH && !final_byte) begin
        mode_nxt  = M_SLASH;
        begin_nxt = pos_r;
      end else if (punct[5]) begin
        c_v[1] = 1'b1; c_cls[1] = punct[4:0]; c_beg[1] = pos_r; c_end[1] = pos_next;
      end else begin
        begin_nxt = pos_r;
        esc_nxt   = 2'd0;
        priority if (is_dec) begin
          mode_nxt = M_NUMBER;
        end else if (text_byte == CH_SQUOTE) begin
          mode_nxt = M_CHAR;
        end else if (text_byte == CH_DQUOTE) begin
          mode_nxt = M_STRING;
        end else if (is_word) begin
          mode_nxt = M_IDENT;
        end else begin
          c_v[1] = 1'b1; c_cls[1] = C_UNKNOWN; c_beg[1] = pos_r; c_end[1] = pos_next;
        end
      end
    end

    if (final_byte) begin
      c_beg[2] = begin_nxt;
      c_end[2] = pos_next;
      unique case (mode_nxt)
        M_NUMBER:                 begin c_v[2] = 1'b1; c_cls[2] = C_NUMBER; end
        M_IDENT:                  begin c_v[2] = 1'b1; c_cls[2] = C_IDENT;  end
        M_CHAR, M_CHAR_ESC:       begin c_v[2] = 1'b1; c_cls[2] = C_CHAR;   end
        M_STRING, M_STRING_ESC:   begin c_v[2] = 1'b1; c_cls[2] = C_STRING; end
        M_SLASH:                  begin c_v[2] = 1'b1; c_cls[2] = C_SLASH;  end
        default:                  c_v[2] = 1'b0;
      endcase
      c_v[3]    = 1'b1;
      mode_nxt  = M_IDLE;
      esc_nxt   = 2'd0;
      begin_nxt = '0;
      pos_nxt   = '0;
    end else begin
      pos_nxt = pos_next;
    end
  end

  always_comb begin
    push_c = '0;
    n      = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (c_v[k] && n != 2'd3) begin
        push_c.item[n].token_class  = c_cls[k];
        push_c.item[n].token_offset = c_beg[k][PW-1] ? OFF_SAT : c_beg[k][cst_pkg::OFFSET_W-1:0];
        push_c.item[n].token_length =
          cst_pkg::LENGTH_W'((c_end[k] >= c_beg[k]) ? c_end[k] - c_beg[k] : '0);
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) push_c.item[n - 2'd1].last_of_run = 1'b1;
    push_c.cnt = accept ? cst_pkg::RCNT_W'(n) : '0;
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      esc_r   <= 2'd0;
      begin_r <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      esc_r   <= esc_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ===== rtl/cst_result_fifo.sv =====
`timescale 1ns / 1ps
module cst_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  cst_pkg::push_t      push,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output cst_pkg::result_t    out_item
);

  localparam int unsigned PW = cst_pkg::PTR_W;
  localparam int unsigned CW = cst_pkg::CNT_W;

  cst_pkg::result_t mem_r [cst_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_item  = mem_r[rd_ptr_r];
  assign full      = (cnt_r > CW'(cst_pkg::FIFO_DEPTH - cst_pkg::MAX_RESULTS));

  assign wr_ptr_nxt = wr_ptr_r + PW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign cnt_nxt    = cnt_r + CW'(push.cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < cst_pkg::MAX_RESULTS; k++) begin
      if (cst_pkg::RCNT_W'(k) < push.cnt) begin
        mem_r[PW'(wr_ptr_r + PW'(k))] <= push.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/c_like_source_tokenizer_top.sv =====
`timescale 1ns / 1ps
// The results of an accepted byte are registered into the result queue and offered from there.
// Throughput: one byte per cycle while in_stall is low; results leave at one per cycle
// while out_stall is low, from an 8-entry result queue; a byte causes up to 3 results.
// in_stall rises while the queue has fewer than 3 free entries.
// Reset (rst_n low, synchronous) returns the lexer to idle at offset 0 and empties the queue.
module c_like_source_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_class,
  output logic [19:0] out_token_offset,
  output logic [20:0] out_token_length,
  output logic        out_last_of_run
);

  cst_pkg::push_t   push;
  cst_pkg::result_t out_item;
  logic             full;
  logic             accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  cst_lexer u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .text_byte  (in_text_byte),
    .final_byte (in_final_byte),
    .push       (push)
  );

  cst_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_token_class  = out_item.token_class;
  assign out_token_offset = out_item.token_offset;
  assign out_token_length = out_item.token_length;
  assign out_last_of_run  = out_item.last_of_run;

endmodule

// ===== sim/tb_c_like_source_tokenizer_top.sv =====
`timescale 1ns / 1ps
module tb_c_like_source_tokenizer_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_ITEMS = 480;
  localparam int ERR_PRINT_MAX = 100;
  localparam int unsigned OFF_MAX = (1 << cst_pkg::OFFSET_W) - 1;

  localparam logic [4:0] CL_LPAREN = 5'd0;
  localparam logic [4:0] CL_SLASH = 5'd14;
  localparam logic [4:0] CL_IDENT = 5'd21;
  localparam logic [4:0] CL_NUMBER = 5'd22;
  localparam logic [4:0] CL_CHAR = 5'd23;
  localparam logic [4:0] CL_STRING = 5'd24;
  localparam logic [4:0] CL_UNKNOWN = 5'd25;
  localparam logic [4:0] CL_END = 5'd26;

  localparam logic [7:0] CH_POUND = "#";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_STAR = "*";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_SQUOTE = "'";
  localparam logic [7:0] CH_DQUOTE = "\"";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_LX = "x";
  localparam logic [7:0] CH_UX = "X";
  localparam logic [7:0] CH_DOT = ".";
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;

  // punctuation in class order
  localparam logic [8*21-1:0] PUNCT = "(){}[],.*-+!~\\/=&#;:?";

  typedef enum logic [3:0] {
    LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_NUMBER, LX_IDENT,
    LX_CHAR, LX_CHAR_ESC, LX_STRING, LX_STRING_ESC
  } lex_mode_e;

  typedef struct packed {
    logic [7:0]       text;
    logic             fin;
    logic             typed;
    cst_pkg::result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_text_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_token_class;
  logic [19:0] out_token_offset;
  logic [20:0] out_token_length;
  logic        out_last_of_run;

  c_like_source_tokenizer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_class  (out_token_class),
    .out_token_offset (out_token_offset),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  lex_mode_e   lex_mode;
  logic [1:0]  esc_left;
  int unsigned tok_start;
  int unsigned byte_pos;

  cst_pkg::result_t run_q[$];
  cst_pkg::result_t token_q[$];
  logic [7:0]       text_q[$];
  dir_row_t         dir_q[$];

  string word_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string word_tail = "azAZ_09qQxX5";
  string digits = "0123456789";
  string num_tail = "0123456789.xX";
  string hex_chars = "0123456789abcdefABCDEF";

  int err_cnt = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit no_gaps = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] punct_at(int i);
    return PUNCT[8*(20-i) +: 8];
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_dec(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic void lex_clear();
    lex_mode = LX_IDLE;
    esc_left = '0;
    tok_start = 0;
    byte_pos = 0;
  endfunction

  function automatic void add_token(logic [4:0] cls, int unsigned first, int unsigned stop);
    cst_pkg::result_t r;
    int unsigned len;
    len = (stop >= first) ? stop - first : 0;
    if (len > cst_pkg::MAX_TEXT_BYTES) len = cst_pkg::MAX_TEXT_BYTES;
    r.token_class = cls;
    r.token_offset = (first > OFF_MAX) ? OFF_MAX[19:0] : first[19:0];
    r.token_length = len[20:0];
    r.last_of_run = 1'b0;
    run_q.push_back(r);
  endfunction

  function automatic void lex_start(logic [7:0] b, logic fin, int unsigned pos,
                                    int unsigned nxt);
    int i;
    if (is_space(b)) return;
    if (b == CH_POUND && !fin) begin
      lex_mode = LX_LINE;
      return;
    end
    if (b == CH_SLASH && !fin) begin
      lex_mode = LX_SLASH;
      tok_start = pos;
      return;
    end
    for (i = 0; i < 21; i++) begin
      if (punct_at(i) == b) begin
        add_token(i[4:0], pos, nxt);
        return;
      end
    end
    tok_start = pos;
    esc_left = '0;
    if (is_dec(b)) lex_mode = LX_NUMBER;
    else if (b == CH_SQUOTE) lex_mode = LX_CHAR;
    else if (b == CH_DQUOTE) lex_mode = LX_STRING;
    else if (is_word(b)) lex_mode = LX_IDENT;
    else add_token(CL_UNKNOWN, pos, nxt);
  endfunction

  // fills run_q with the tokens that one byte causes
  function automatic void lex_byte(logic [7:0] b, logic fin);
    int unsigned pos;
    int unsigned nxt;
    cst_pkg::result_t r;
    pos = byte_pos;
    nxt = (pos < cst_pkg::MAX_TEXT_BYTES) ? pos + 1 : cst_pkg::MAX_TEXT_BYTES;
    run_q.delete();
    case (lex_mode)
      LX_SLASH: begin
        if (b == CH_SLASH) lex_mode = LX_LINE;
        else if (b == CH_STAR) lex_mode = LX_BLOCK;
        else begin
          add_token(CL_SLASH, tok_start, pos);
          lex_mode = LX_IDLE;
          lex_start(b, fin, pos, nxt);
        end
      end
      LX_LINE: if (b == CH_NL) lex_mode = LX_IDLE;
      LX_BLOCK: if (b == CH_STAR) lex_mode = LX_BLOCK_STAR;
      LX_BLOCK_STAR: begin
        if (b == CH_SLASH) lex_mode = LX_IDLE;
        else if (b != CH_STAR) lex_mode = LX_BLOCK;
      end
      LX_NUMBER: begin
        if (!(is_dec(b) || b == CH_DOT || b == CH_LX || b == CH_UX)) begin
          add_token(CL_NUMBER, tok_start, pos);
          lex_mode = LX_IDLE;
          lex_start(b, fin, pos, nxt);
        end
      end
      LX_IDENT: begin
        if (!(is_word(b) || is_dec(b))) begin
          add_token(CL_IDENT, tok_start, pos);
          lex_mode = LX_IDLE;
          lex_start(b, fin, pos, nxt);
        end
      end
      LX_CHAR, LX_STRING: begin
        if (esc_left > 0) esc_left = esc_left - 1'b1;
        else if (b == CH_BSLASH) lex_mode = (lex_mode == LX_CHAR) ? LX_CHAR_ESC : LX_STRING_ESC;
        else if (b == ((lex_mode == LX_CHAR) ? CH_SQUOTE : CH_DQUOTE)) begin
          add_token((lex_mode == LX_CHAR) ? CL_CHAR : CL_STRING, tok_start, nxt);
          lex_mode = LX_IDLE;
        end
      end
      LX_CHAR_ESC, LX_STRING_ESC: begin
        esc_left = (b == CH_LX) ? 2'd2 : 2'd0;
        lex_mode = (lex_mode == LX_CHAR_ESC) ? LX_CHAR : LX_STRING;
      end
      default: begin
        lex_mode = LX_IDLE;
        lex_start(b, fin, pos, nxt);
      end
    endcase

    if (fin) begin
      case (lex_mode)
        LX_NUMBER: add_token(CL_NUMBER, tok_start, nxt);
        LX_IDENT: add_token(CL_IDENT, tok_start, nxt);
        LX_CHAR, LX_CHAR_ESC: add_token(CL_CHAR, tok_start, nxt);
        LX_STRING, LX_STRING_ESC: add_token(CL_STRING, tok_start, nxt);
        LX_SLASH: add_token(CL_SLASH, tok_start, nxt);
        default: ;
      endcase
      add_token(CL_END, nxt, nxt);
      lex_clear();
    end else begin
      byte_pos = nxt;
    end

    if (run_q.size() > 0) begin
      r = run_q.pop_back();
      r.last_of_run = 1'b1;
      run_q.push_back(r);
    end
  endfunction

  function automatic void row(logic [7:0] b, logic fin);
    dir_row_t d;
    d = '0;
    d.text = b;
    d.fin = fin;
    dir_q.push_back(d);
  endfunction

  function automatic void row_typed(logic [7:0] b, logic fin, logic [4:0] cls,
                                    int unsigned off, int unsigned len);
    dir_row_t d;
    d.text = b;
    d.fin = fin;
    d.typed = 1'b1;
    d.want.token_class = cls;
    d.want.token_offset = off[19:0];
    d.want.token_length = len[20:0];
    d.want.last_of_run = 1'b1;
    dir_q.push_back(d);
  endfunction

  function automatic void add_lit_char();
    if ($urandom_range(0, 3) == 0) begin
      text_q.push_back(CH_BSLASH);
      if ($urandom_range(0, 1)) begin
        text_q.push_back(CH_LX);
        text_q.push_back(pick(hex_chars));
        text_q.push_back(pick(hex_chars));
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_piece();
    case ($urandom_range(0, 12))
      0, 1: begin
        text_q.push_back(pick(word_head));
        repeat ($urandom_range(0, 6)) text_q.push_back(pick(word_tail));
      end
      2: begin
        text_q.push_back(pick(digits));
        repeat ($urandom_range(0, 5)) text_q.push_back(pick(num_tail));
      end
      3, 4: text_q.push_back(punct_at($urandom_range(0, 20)));
      5: begin
        repeat ($urandom_range(1, 3))
          text_q.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
      end
      6: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_SLASH);
        repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(0, 255)));
        text_q.push_back(CH_NL);
      end
      7: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_STAR);
        repeat ($urandom_range(0, 8))
          text_q.push_back(($urandom_range(0, 2) == 0) ? CH_STAR : 8'($urandom_range(0, 255)));
        text_q.push_back(CH_STAR);
        text_q.push_back(CH_SLASH);
      end
      8: begin
        text_q.push_back(CH_POUND);
        repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(0, 255)));
        text_q.push_back(CH_NL);
      end
      9: begin
        text_q.push_back(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) add_lit_char();
        text_q.push_back(CH_DQUOTE);
      end
      10: begin
        text_q.push_back(CH_SQUOTE);
        add_lit_char();
        text_q.push_back(CH_SQUOTE);
      end
      11: text_q.push_back(8'($urandom_range(0, 255)));
      default: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back($urandom_range(0, 1) ? CH_SPACE : pick(word_head));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (err_cnt < ERR_PRINT_MAX) $display("%0t mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input cst_pkg::result_t want);
    while (!no_gaps && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    lex_byte(b, fin);
    if (typed) token_q.push_back(want);
    else foreach (run_q[i]) token_q.push_back(run_q[i]);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin : check_tokens
    cst_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (token_q.size() == 0) begin
        report_mismatch($sformatf("unexpected token class %0d offset %0d",
                                  out_token_class, out_token_offset));
      end else begin
        want = token_q.pop_front();
        if (out_token_class !== want.token_class)
          report_mismatch($sformatf("class %0d, want %0d",
                                    out_token_class, want.token_class));
        if (out_token_offset !== want.token_offset)
          report_mismatch($sformatf("offset %0d, want %0d",
                                    out_token_offset, want.token_offset));
        if (out_token_length !== want.token_length)
          report_mismatch($sformatf("length %0d, want %0d",
                                    out_token_length, want.token_length));
        if (out_last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, want %0b",
                                    out_last_of_run, want.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int text_cnt;
    int random_sent;
    int k;
    logic [7:0] c;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_final_byte = 1'b0;
    out_stall = 1'b0;
    lex_clear();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    row_typed(8'h00, 1'b0, CL_UNKNOWN, 0, 1);
    row(8'hFF, 1'b1);
    row_typed("(", 1'b0, CL_LPAREN, 0, 1);
    row("9", 1'b0);
    row(CH_UX, 1'b0);
    row(CH_DOT, 1'b0);
    row(CH_POUND, 1'b1);
    row("_", 1'b0);
    row(CH_SLASH, 1'b0);
    row(CH_SLASH, 1'b0);
    row(CH_NL, 1'b0);
    row(CH_SLASH, 1'b0);
    row(CH_STAR, 1'b0);
    row(CH_STAR, 1'b0);
    row(CH_SLASH, 1'b0);
    row(CH_DQUOTE, 1'b0);
    row(CH_BSLASH, 1'b0);
    row(CH_LX, 1'b0);
    row(CH_DQUOTE, 1'b0);
    row(CH_DQUOTE, 1'b0);
    row(CH_DQUOTE, 1'b0);
    row(CH_SQUOTE, 1'b0);
    row(CH_BSLASH, 1'b1);
    row(CH_SLASH, 1'b1);
    row_typed(CH_TAB, 1'b1, CL_END, 1, 0);

    foreach (dir_q[i]) send_byte(dir_q[i].text, dir_q[i].fin, dir_q[i].typed, dir_q[i].want);

    text_cnt = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      no_gaps = (text_cnt >= 4 && text_cnt < 10);
      text_q.delete();
      if (text_cnt == 12) begin
        // receiver holds off while a dense run of tokens fills the block
        hold_req = 1'b1;
        repeat (40) begin
          do c = punct_at($urandom_range(0, 20)); while (c == CH_SLASH || c == CH_POUND);
          text_q.push_back(c);
        end
      end else begin
        repeat ($urandom_range(1, 8)) add_piece();
        // cut short now and then so the text ends inside a token
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(1, text_q.size());
          while (text_q.size() > k) text_q.delete(text_q.size() - 1);
        end
      end
      send_text();
      random_sent += text_q.size();
      text_cnt++;
    end

    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
